[design/ars_pkg.sv]
// Shared types and constants for the adaptive run merge sorter.
// Used by ars_ctrl, ars_dp and the top level; depends on nothing.
package ars_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int IDX_W   = $clog2(DEPTH + 1);
	localparam int STACK_N = DEPTH + 1;
	localparam int MRUN_W  = 7;
	localparam logic [MRUN_W-1:0] MIN_RUN_RST = MRUN_W'(32);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} out_item_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_INIT, ST_RUN,
		ST_ASC_RD, ST_ASC_CMP, ST_ASC_END,
		ST_DSC_RD, ST_DSC_CMP, ST_DSC_END,
		ST_REV_RD, ST_REV_W1, ST_REV_W2,
		ST_INS_OUT, ST_INS_RD, ST_INS_CMP, ST_INS_W1, ST_INS_W2,
		ST_PUSH, ST_CHK, ST_STK_RD, ST_STK_CAP, ST_EVAL,
		ST_MRG_RD, ST_MRG_W, ST_CPY_RD, ST_CPY_W,
		ST_POST_L1, ST_POST_L2, ST_POST_T,
		ST_FINAL, ST_OUT_INIT, ST_OUT_RD, ST_OUT_LD, ST_DONE
	} state_t;

	typedef enum logic [1:0] {MK_NONE, MK_TOP, MK_LOW} merge_kind_t;

	typedef enum logic [1:0] {DSEL_IN, DSEL_A, DSEL_B, DSEL_S} dsel_t;

	typedef enum logic {SSEL_A, SSEL_B} ssel_t;

	typedef struct packed {
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic              d_we;
		logic [ADDR_W-1:0] d_waddr;
		dsel_t             d_wsel;
		logic              s_we;
		logic [ADDR_W-1:0] s_waddr;
		ssel_t             s_wsel;
		logic [ADDR_W-1:0] s_raddr;
		logic              st_we;
		logic [IDX_W-1:0]  st_waddr;
		logic [IDX_W-1:0]  st_wdata;
		logic [IDX_W-1:0]  st_raddr;
		logic              out_load;
		logic              out_last;
		logic              out_ovf;
	} cmd_t;

	typedef struct packed {
		logic             lt_ba;
		logic [IDX_W-1:0] st_rdata;
	} status_t;

endpackage

[design/adaptive_run_merge_sorter.sv]
// Adaptive run merge sorter, top level. Loads accept one item per cycle while load_stall
// is low; after the last item load_stall rises and the set is sorted in place by run
// scans, insertion sort and merges (merge pass plus copy back through one write port).
// Output: each sorted item is read into a register, then loaded into the output register.
// Reset clears control state only; element memories need no clearing pass.
module adaptive_run_merge_sorter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load_valid,
	output logic                       load_stall,
	input  ars_pkg::in_item_t          load_item,
	output logic                       sort_valid,
	input  logic                       sort_stall,
	output ars_pkg::out_item_t         sort_item,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ars_pkg::MRUN_W-1:0] cfg_data
);
	import ars_pkg::*;

	cmd_t    cmd;
	status_t stat;

	ars_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.last_in    (load_item.last_in),
		.load_stall (load_stall),
		.sort_valid (sort_valid),
		.sort_stall (sort_stall),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.stat       (stat)
	);

	ars_dp u_dp (
		.clk   (clk),
		.value (load_item.value),
		.cmd   (cmd),
		.stat  (stat),
		.item  (sort_item)
	);

`ifndef SYNTHESIS
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_valid && !load_stall && load_item.last_in) |=> load_stall)
		else $error("loader not busy after last item");

	a_ovf_per_set: assert property (@(posedge clk) disable iff (!arst_n)
		(sort_valid && !sort_stall && !sort_item.last_out)
		|=> (sort_item.overflow == $past(sort_item.overflow)))
		else $error("overflow flag changed within a set");
`endif

endmodule

[design/ars_dp.sv]
// Datapath: element memory, scratch memory, run boundary stack, compare, output register.
// Driven by cmd_t from ars_ctrl; types from ars_pkg.
module ars_dp (
	input  logic                      clk,
	input  logic signed [31:0]        value,
	input  ars_pkg::cmd_t             cmd,
	output ars_pkg::status_t          stat,
	output ars_pkg::out_item_t        item
);
	import ars_pkg::*;

	logic signed [31:0] mem_q [DEPTH];
	logic signed [31:0] scr_q [DEPTH];
	logic [IDX_W-1:0]   stk_q [STACK_N];
	logic signed [31:0] ra_q, rb_q, sr_q;
	logic [IDX_W-1:0]   st_rd_q;
	logic signed [31:0] d_wdata, s_wdata;
	out_item_t          out_q;

	always_comb begin
		case (cmd.d_wsel)
			DSEL_IN: d_wdata = value;
			DSEL_A:  d_wdata = ra_q;
			DSEL_B:  d_wdata = rb_q;
			DSEL_S:  d_wdata = sr_q;
			default: d_wdata = value;
		endcase
		s_wdata = (cmd.s_wsel == SSEL_B) ? rb_q : ra_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.d_we) begin
			mem_q[cmd.d_waddr] <= d_wdata;
		end
		ra_q <= mem_q[cmd.a_addr];
		rb_q <= mem_q[cmd.b_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.s_we) begin
			scr_q[cmd.s_waddr] <= s_wdata;
		end
		sr_q <= scr_q[cmd.s_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			stk_q[cmd.st_waddr] <= cmd.st_wdata;
		end
		st_rd_q <= stk_q[cmd.st_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.sorted_value <= ra_q;
			out_q.last_out     <= cmd.out_last;
			out_q.overflow     <= cmd.out_ovf;
		end
	end

	assign stat.lt_ba    = rb_q < ra_q;
	assign stat.st_rdata = st_rd_q;
	assign item          = out_q;

endmodule

[design/ars_ctrl.sv]
// Controller: load, run detection, insertion sort, merge sequencing and output.
// Issues cmd_t to ars_dp and reads status_t back; types from ars_pkg.
module ars_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load_valid,
	input  logic                       last_in,
	output logic                       load_stall,
	output logic                       sort_valid,
	input  logic                       sort_stall,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ars_pkg::MRUN_W-1:0] cfg_data,
	output ars_pkg::cmd_t              cmd,
	input  ars_pkg::status_t           stat
);
	import ars_pkg::*;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  fill_q, n_q, pos_q, i_q, j_q, k_q, lo_q, mid_q, hi_q, end_q, sd_q;
	logic [IDX_W-1:0]  t_q [4];
	logic [MRUN_W-1:0] minrun_q;
	logic              drop_q, fin_q, outv_q, low_q;

	logic              acc, out_free, take_b, out_last;
	logic [IDX_W-1:0]  run_len, rem, ea, eb, ec, k1;
	logic [IDX_W:0]    pos_plus, bc;
	logic [2:0]        need;
	merge_kind_t       kind;

	assign acc        = load_valid && !load_stall;
	assign load_stall = (state_q != ST_IDLE);
	assign sort_valid = outv_q;
	assign cfg_ready  = 1'b1;
	assign out_free   = !outv_q || !sort_stall;
	assign k1         = k_q + IDX_W'(1);
	assign out_last   = (k1 == n_q);

	always_comb begin
		run_len  = i_q - pos_q;
		rem      = n_q - pos_q;
		pos_plus = {1'b0, pos_q} + (IDX_W + 1)'(minrun_q);
		need     = (!fin_q && sd_q > IDX_W'(3)) ? 3'd4 : 3'd3;
		ea       = t_q[0] - t_q[1];
		eb       = t_q[1] - t_q[2];
		ec       = t_q[2] - t_q[3];
		bc       = {1'b0, eb} + {1'b0, ec};
		take_b   = (i_q == mid_q) || ((j_q != hi_q) && stat.lt_ba);
		if (fin_q) begin
			kind = MK_TOP;
		end else if (sd_q == IDX_W'(3)) begin
			kind = (ea <= eb) ? MK_TOP : MK_NONE;
		end else if ({1'b0, ea} <= bc) begin
			kind = (ea >= ec) ? MK_LOW : MK_NONE;
		end else begin
			kind = MK_TOP;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (acc && last_in) state_d = ST_INIT;
			ST_INIT:    state_d = ST_RUN;
			ST_RUN:     state_d = (pos_q >= n_q) ? ST_FINAL : ST_ASC_RD;
			ST_ASC_RD:  state_d = (i_q + IDX_W'(1) >= n_q) ? ST_ASC_END : ST_ASC_CMP;
			ST_ASC_CMP: state_d = stat.lt_ba ? ST_ASC_END : ST_ASC_RD;
			ST_ASC_END: state_d = (run_len >= minrun_q) ? ST_PUSH : ST_DSC_RD;
			ST_DSC_RD:  state_d = (i_q + IDX_W'(1) >= n_q) ? ST_DSC_END : ST_DSC_CMP;
			ST_DSC_CMP: state_d = stat.lt_ba ? ST_DSC_RD : ST_DSC_END;
			ST_DSC_END: state_d = (run_len >= minrun_q) ? ST_REV_RD : ST_INS_OUT;
			ST_REV_RD:  state_d = (lo_q < hi_q) ? ST_REV_W1 : ST_PUSH;
			ST_REV_W1:  state_d = ST_REV_W2;
			ST_REV_W2:  state_d = ST_REV_RD;
			ST_INS_OUT: state_d = (i_q >= end_q) ? ST_PUSH : ST_INS_RD;
			ST_INS_RD:  state_d = (j_q > pos_q) ? ST_INS_CMP : ST_INS_OUT;
			ST_INS_CMP: state_d = stat.lt_ba ? ST_INS_W1 : ST_INS_OUT;
			ST_INS_W1:  state_d = ST_INS_W2;
			ST_INS_W2:  state_d = ST_INS_RD;
			ST_PUSH:    state_d = ST_CHK;
			ST_CHK:     state_d = (sd_q < IDX_W'(3)) ? ST_RUN : ST_STK_RD;
			ST_STK_RD:  state_d = ST_STK_CAP;
			ST_STK_CAP: state_d = (k1 == IDX_W'(need)) ? ST_EVAL : ST_STK_RD;
			ST_EVAL:    state_d = (kind == MK_NONE) ? ST_RUN : ST_MRG_RD;
			ST_MRG_RD:  state_d = (k_q >= hi_q) ? ST_CPY_RD : ST_MRG_W;
			ST_MRG_W:   state_d = ST_MRG_RD;
			ST_CPY_RD: begin
				if (k_q < hi_q) begin
					state_d = ST_CPY_W;
				end else begin
					state_d = low_q ? ST_POST_L1 : ST_POST_T;
				end
			end
			ST_CPY_W:   state_d = ST_CPY_RD;
			ST_POST_L1: state_d = ST_POST_L2;
			ST_POST_L2: state_d = fin_q ? ST_FINAL : ST_RUN;
			ST_POST_T:  state_d = fin_q ? ST_FINAL : ST_RUN;
			ST_FINAL:   state_d = (sd_q > IDX_W'(2)) ? ST_STK_RD : ST_OUT_INIT;
			ST_OUT_INIT: state_d = ST_OUT_RD;
			ST_OUT_RD:  state_d = ST_OUT_LD;
			ST_OUT_LD: begin
				if (out_free) begin
					state_d = out_last ? ST_DONE : ST_OUT_RD;
				end
			end
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath commands; read addresses stay put while their data is still in use
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.d_we    = acc && (fill_q < IDX_W'(DEPTH));
				cmd.d_waddr = fill_q[ADDR_W-1:0];
				cmd.d_wsel  = DSEL_IN;
			end
			ST_INIT: begin
				cmd.st_we    = 1'b1;
				cmd.st_waddr = '0;
				cmd.st_wdata = '0;
			end
			ST_ASC_RD, ST_DSC_RD: begin
				cmd.a_addr = i_q[ADDR_W-1:0];
				cmd.b_addr = ADDR_W'(i_q + IDX_W'(1));
			end
			ST_REV_RD: begin
				cmd.a_addr = lo_q[ADDR_W-1:0];
				cmd.b_addr = hi_q[ADDR_W-1:0];
			end
			ST_REV_W1: begin
				cmd.a_addr  = lo_q[ADDR_W-1:0];
				cmd.b_addr  = hi_q[ADDR_W-1:0];
				cmd.d_we    = 1'b1;
				cmd.d_waddr = lo_q[ADDR_W-1:0];
				cmd.d_wsel  = DSEL_B;
			end
			ST_REV_W2: begin
				cmd.d_we    = 1'b1;
				cmd.d_waddr = hi_q[ADDR_W-1:0];
				cmd.d_wsel  = DSEL_A;
			end
			ST_INS_RD, ST_INS_CMP: begin
				cmd.a_addr = ADDR_W'(j_q - IDX_W'(1));
				cmd.b_addr = j_q[ADDR_W-1:0];
			end
			ST_INS_W1: begin
				cmd.a_addr  = ADDR_W'(j_q - IDX_W'(1));
				cmd.b_addr  = j_q[ADDR_W-1:0];
				cmd.d_we    = 1'b1;
				cmd.d_waddr = ADDR_W'(j_q - IDX_W'(1));
				cmd.d_wsel  = DSEL_B;
			end
			ST_INS_W2: begin
				cmd.d_we    = 1'b1;
				cmd.d_waddr = j_q[ADDR_W-1:0];
				cmd.d_wsel  = DSEL_A;
			end
			ST_PUSH: begin
				cmd.st_we    = 1'b1;
				cmd.st_waddr = sd_q;
				cmd.st_wdata = end_q;
			end
			ST_STK_RD: cmd.st_raddr = sd_q - IDX_W'(1) - k_q;
			ST_MRG_RD: begin
				cmd.a_addr = i_q[ADDR_W-1:0];
				cmd.b_addr = j_q[ADDR_W-1:0];
			end
			ST_MRG_W: begin
				cmd.s_we    = 1'b1;
				cmd.s_waddr = k_q[ADDR_W-1:0];
				cmd.s_wsel  = take_b ? SSEL_B : SSEL_A;
			end
			ST_CPY_RD: cmd.s_raddr = k_q[ADDR_W-1:0];
			ST_CPY_W: begin
				cmd.d_we    = 1'b1;
				cmd.d_waddr = k_q[ADDR_W-1:0];
				cmd.d_wsel  = DSEL_S;
			end
			ST_POST_L1: begin
				cmd.st_we    = 1'b1;
				cmd.st_waddr = sd_q - IDX_W'(3);
				cmd.st_wdata = t_q[1];
			end
			ST_POST_L2, ST_POST_T: begin
				cmd.st_we    = 1'b1;
				cmd.st_waddr = sd_q - IDX_W'(2);
				cmd.st_wdata = t_q[0];
			end
			ST_OUT_RD: cmd.a_addr = k_q[ADDR_W-1:0];
			ST_OUT_LD: begin
				cmd.a_addr   = k_q[ADDR_W-1:0];
				cmd.out_load = out_free;
				cmd.out_last = out_last;
				cmd.out_ovf  = drop_q;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			sd_q     <= IDX_W'(1);
			drop_q   <= 1'b0;
			fin_q    <= 1'b0;
			outv_q   <= 1'b0;
			minrun_q <= MIN_RUN_RST;
		end else begin
			state_q <= state_d;
			outv_q  <= (outv_q && sort_stall) || cmd.out_load;
			if (cfg_valid) begin
				minrun_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (fill_q < IDX_W'(DEPTH)) begin
							fill_q <= fill_q + IDX_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_INIT: begin
					sd_q  <= IDX_W'(1);
					fin_q <= 1'b0;
				end
				ST_POST_L2, ST_POST_T: sd_q <= sd_q - IDX_W'(1);
				ST_PUSH:  sd_q <= sd_q + IDX_W'(1);
				ST_FINAL: fin_q <= 1'b1;
				ST_DONE: begin
					fill_q <= '0;
					sd_q   <= IDX_W'(1);
					drop_q <= 1'b0;
					fin_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// index registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= (fill_q < IDX_W'(DEPTH)) ? fill_q + IDX_W'(1) : fill_q;
			end
			ST_INIT:    pos_q <= '0;
			ST_RUN:     i_q <= pos_q;
			ST_ASC_CMP, ST_DSC_CMP: begin
				if (stat.lt_ba == (state_q == ST_DSC_CMP)) begin
					i_q <= i_q + IDX_W'(1);
				end
			end
			ST_ASC_END: begin
				end_q <= i_q + IDX_W'(1);
				i_q   <= pos_q;
			end
			ST_DSC_END: begin
				if (run_len >= minrun_q) begin
					lo_q  <= pos_q;
					hi_q  <= i_q;
					end_q <= i_q + IDX_W'(1);
				end else begin
					i_q   <= pos_q + IDX_W'(1);
					end_q <= (rem <= IDX_W'(minrun_q)) ? n_q : pos_plus[IDX_W-1:0];
				end
			end
			ST_REV_W2: begin
				lo_q <= lo_q + IDX_W'(1);
				hi_q <= hi_q - IDX_W'(1);
			end
			ST_INS_OUT: j_q <= i_q;
			ST_INS_RD:  if (j_q <= pos_q) i_q <= i_q + IDX_W'(1);
			ST_INS_CMP: if (!stat.lt_ba) i_q <= i_q + IDX_W'(1);
			ST_INS_W2:  j_q <= j_q - IDX_W'(1);
			ST_PUSH:    pos_q <= end_q;
			ST_CHK, ST_FINAL: k_q <= '0;
			ST_STK_CAP: begin
				t_q[k_q[1:0]] <= stat.st_rdata;
				k_q <= k1;
			end
			ST_EVAL: begin
				low_q <= (kind == MK_LOW);
				if (kind == MK_LOW) begin
					lo_q  <= t_q[3];
					mid_q <= t_q[2];
					hi_q  <= t_q[1];
					i_q   <= t_q[3];
					j_q   <= t_q[2];
					k_q   <= t_q[3];
				end else begin
					lo_q  <= t_q[2];
					mid_q <= t_q[1];
					hi_q  <= t_q[0];
					i_q   <= t_q[2];
					j_q   <= t_q[1];
					k_q   <= t_q[2];
				end
			end
			ST_MRG_RD:  if (k_q >= hi_q) k_q <= lo_q;
			ST_MRG_W: begin
				if (take_b) begin
					j_q <= j_q + IDX_W'(1);
				end else begin
					i_q <= i_q + IDX_W'(1);
				end
				k_q <= k1;
			end
			ST_CPY_W:    k_q <= k1;
			ST_OUT_INIT: k_q <= '0;
			ST_OUT_LD:   if (out_free) k_q <= k1;
			default: ;
		endcase
	end

endmodule

[dv/tb_top.sv]
// Self-checking bench for adaptive_run_merge_sorter: sets of signed words are loaded,
// sorted results are compared with an in-bench run-merge predictor, with min_run changes.
// Depends on ars_pkg (item types, MRUN_W) and the adaptive_run_merge_sorter RTL.
module tb_top;
	import ars_pkg::*;

	localparam int CAP     = 64;
	localparam int LIMIT   = 1000000;
	localparam int SETTLE  = 40;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic signed [31:0] value;
		bit                 last;
		bit                 fixed;
		out_item_t          want;
	} load_row_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              load_valid = 0;
	logic              load_stall;
	in_item_t          load_item = '0;
	logic              sort_valid;
	logic              sort_stall = 0;
	out_item_t         sort_item;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic [MRUN_W-1:0] cfg_data = '0;

	adaptive_run_merge_sorter uut (
		.clk(clk), .arst_n(arst_n),
		.load_valid(load_valid), .load_stall(load_stall), .load_item(load_item),
		.sort_valid(sort_valid), .sort_stall(sort_stall), .sort_item(sort_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// predictor state
	logic signed [31:0] set_mem [CAP];
	logic signed [31:0] merge_buf [CAP];
	int                 bounds [CAP+1];
	int                 bound_cnt;
	int                 set_fill;
	bit                 set_dropped;
	int                 min_run_cfg;
	out_item_t          sorted_q [$];

	int         fails;
	int         cycles;
	int         sent;
	idle_mode_t idle_mode;
	bit         hold_req;
	int         hold_left;

	function automatic void flip_span(int lo, int hi);
		logic signed [31:0] t;
		while (lo < hi) begin
			t = set_mem[lo]; set_mem[lo] = set_mem[hi]; set_mem[hi] = t;
			lo++; hi--;
		end
	endfunction

	function automatic void insertion_pass(int lo, int hi);
		int j;
		logic signed [31:0] t;
		for (int i = lo + 1; i < hi; i++) begin
			j = i;
			while (j > lo && set_mem[j] < set_mem[j-1]) begin
				t = set_mem[j]; set_mem[j] = set_mem[j-1]; set_mem[j-1] = t;
				j--;
			end
		end
	endfunction

	function automatic void merge_span(int lo, int mid, int hi);
		int i, j;
		i = lo; j = mid;
		if (hi > CAP || mid > hi || lo > mid)
			return;
		for (int k = lo; k < hi; k++) begin
			if (i == mid) merge_buf[k] = set_mem[j++];
			else if (j == hi) merge_buf[k] = set_mem[i++];
			else if (set_mem[j] < set_mem[i]) merge_buf[k] = set_mem[j++];
			else merge_buf[k] = set_mem[i++];
		end
		for (int k = lo; k < hi; k++)
			set_mem[k] = merge_buf[k];
	endfunction

	function automatic int find_run(int start, int n);
		int i;
		i = start;
		while (i + 1 < n && !(set_mem[i+1] < set_mem[i])) i++;
		if (i - start >= min_run_cfg) return i + 1;
		i = start;
		while (i + 1 < n && set_mem[i+1] < set_mem[i]) i++;
		if (i - start >= min_run_cfg) begin
			flip_span(start, i);
			return i + 1;
		end
		if (n - start <= min_run_cfg) begin
			insertion_pass(start, n);
			return n;
		end
		insertion_pass(start, start + min_run_cfg);
		return start + min_run_cfg;
	endfunction

	function automatic void run_merge_sort(int n);
		int pos, d, a, b, c;
		pos = 0;
		bound_cnt = 1;
		bounds[0] = 0;
		while (pos < n) begin
			pos = find_run(pos, n);
			if (bound_cnt > CAP) break;
			bounds[bound_cnt++] = pos;
			d = bound_cnt;
			if (d > 3) begin
				a = bounds[d-1] - bounds[d-2];
				b = bounds[d-2] - bounds[d-3];
				c = bounds[d-3] - bounds[d-4];
				if (a <= b + c) begin
					if (a >= c) begin
						merge_span(bounds[d-4], bounds[d-3], bounds[d-2]);
						bounds[d-3] = bounds[d-2];
						bounds[d-2] = bounds[d-1];
						bound_cnt--;
					end
				end else begin
					merge_span(bounds[d-3], bounds[d-2], bounds[d-1]);
					bounds[d-2] = bounds[d-1];
					bound_cnt--;
				end
			end else if (d == 3) begin
				b = bounds[2] - bounds[1];
				c = bounds[1] - bounds[0];
				if (b <= c) begin
					merge_span(bounds[0], bounds[1], bounds[2]);
					bounds[1] = bounds[2];
					bound_cnt--;
				end
			end
		end
		while (bound_cnt > 2) begin
			d = bound_cnt;
			merge_span(bounds[d-3], bounds[d-2], bounds[d-1]);
			bounds[d-2] = bounds[d-1];
			bound_cnt--;
		end
	endfunction

	function automatic void predict_load(logic signed [31:0] v, bit last);
		out_item_t r;
		if (set_fill < CAP) set_mem[set_fill++] = v;
		else set_dropped = 1;
		if (!last) return;
		run_merge_sort(set_fill);
		for (int k = 0; k < set_fill; k++) begin
			r.sorted_value = set_mem[k];
			r.last_out     = (k + 1 == set_fill);
			r.overflow     = set_dropped;
			sorted_q.push_back(r);
		end
		set_fill = 0;
		set_dropped = 0;
	endfunction

	// result checker
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && sort_valid && !sort_stall) begin
			if (sorted_q.size() == 0) begin
				$display("%0t: unexpected item %h", $time, sort_item);
				fails++;
			end else begin
				e = sorted_q.pop_front();
				if (sort_item.sorted_value !== e.sorted_value || sort_item.last_out !== e.last_out
						|| sort_item.overflow !== e.overflow) begin
					$display("%0t: mismatch exp %h/%b/%b got %h/%b/%b", $time, e.sorted_value,
						e.last_out, e.overflow, sort_item.sorted_value, sort_item.last_out,
						sort_item.overflow);
					fails++;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 600;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			sort_stall <= 1;
		end else if (idle_mode == IDLE_RECV)
			sort_stall <= ($urandom_range(99) < 64);
		else if (idle_mode == IDLE_BOTH)
			sort_stall <= ($urandom_range(99) < 7);
		else
			sort_stall <= 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_load(logic signed [31:0] v, bit last, bit fixed = 0,
			out_item_t want = '0);
		int pct;
		pct = (idle_mode == IDLE_SEND) ? 64 : (idle_mode == IDLE_BOTH) ? 7 : 0;
		while ($urandom_range(99) < pct) begin
			load_valid <= 0;
			@(posedge clk);
		end
		load_valid <= 1;
		load_item  <= '{value: v, last_in: last};
		@(posedge clk);
		while (load_stall) @(posedge clk);
		predict_load(v, last);
		if (fixed) begin
			void'(sorted_q.pop_back());
			sorted_q.push_back(want);
		end
		sent++;
	endtask

	task automatic drain_and_settle();
		load_valid <= 0;
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_min_run(logic [MRUN_W-1:0] v);
		drain_and_settle();
		cfg_valid <= 1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		min_run_cfg = v;
	endtask

	task automatic send_set(int n, int shape);
		logic signed [31:0] v;
		for (int k = 0; k < n; k++) begin
			case (shape)
			0: v = $urandom;
			1: v = $signed($urandom_range(6)) - 3;
			2: v = k * 3 + $urandom_range(4) - 40;
			3: v = 1000 - k * $urandom_range(5, 1);
			default: v = ($urandom_range(3) == 0) ? $urandom : ((k % 9) < 5 ? k : -k);
			endcase
			send_load(v, k == n - 1);
		end
	endtask

	load_row_t rows [$];
	int        mr_list [$] = '{1, 0, 64, 127, 5, 2, 32, 17};

	initial begin
		fails = 0; cycles = 0; sent = 0;
		idle_mode = IDLE_NONE; hold_req = 0; hold_left = 0;
		set_fill = 0; set_dropped = 0; min_run_cfg = 32;

		rows = '{
			'{32'sh7fffffff, 1, 1, '{32'sh7fffffff, 1'b1, 1'b0}},
			'{32'sh80000000, 1, 1, '{32'sh80000000, 1'b1, 1'b0}},
			'{0, 1, 1, '{32'sh0, 1'b1, 1'b0}},
			'{-1, 1, 1, '{-32'sd1, 1'b1, 1'b0}},
			'{7, 0, 0, '0}, '{7, 0, 0, '0}, '{7, 0, 0, '0}, '{7, 1, 0, '0},
			'{5, 0, 0, '0}, '{3, 0, 0, '0}, '{1, 0, 0, '0}, '{-2, 1, 0, '0},
			'{32'sh7fffffff, 0, 0, '0}, '{32'sh80000000, 0, 0, '0},
			'{0, 0, 0, '0}, '{-1, 0, 0, '0}, '{32'sh55555555, 0, 0, '0},
			'{32'shaaaaaaaa, 0, 0, '0}, '{4, 0, 0, '0}, '{4, 0, 0, '0},
			'{-4, 1, 0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i])
			send_load(rows[i].value, rows[i].last, rows[i].fixed, rows[i].want);
		load_valid <= 0;

		// long receiver hold while two sets are offered
		hold_req = 1;
		send_set(8, 0);
		send_set(5, 4);

		for (int p = 0; sent < 110 || p < mr_list.size(); p++) begin
			write_min_run(mr_list[p % mr_list.size()]);
			idle_mode = idle_mode_t'(p % 4);
			if (p == 2) send_set(66, 0);
			send_set($urandom_range(3, 1), $urandom_range(4));
		end
		idle_mode = IDLE_NONE;
		write_min_run(MIN_RUN_RST);
		send_set(4, 4);
		drain_and_settle();

		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[adaptive_run_merge_sorter.f]
design/ars_pkg.sv
design/ars_dp.sv
design/ars_ctrl.sv
design/adaptive_run_merge_sorter.sv
dv/tb_top.sv
